/* hw/rtl/lmtc_pkg.sv */
// Shared types and constants for the LCD mode timing controller.
// No dependencies; imported by lmtc_rem_unit and lcd_mode_timing_controller.
package lmtc_pkg;

  localparam int ACC_W   = 11;  // cycle accumulator
  localparam int THR_W   = 10;  // mode thresholds
  localparam int LINE_W  = 8;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 10;  // widest configuration register
  localparam int CFG_IDX_W = 3;
  localparam int OFF_W   = 4;
  localparam int CNT_W   = 8;

  // shift-subtract remainder: one step per accumulator bit
  localparam int REM_STEPS = ACC_W;
  localparam int REM_CNT_W = $clog2(REM_STEPS + 1);
  localparam int REM_DW    = THR_W + ACC_W - 1;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_REM,
    ST_FIN
  } seq_state_t;

  // register offsets
  localparam logic [OFF_W-1:0] REG_CTRL  = 4'd0;
  localparam logic [OFF_W-1:0] REG_STAT  = 4'd1;
  localparam logic [OFF_W-1:0] REG_SCY   = 4'd2;
  localparam logic [OFF_W-1:0] REG_SCX   = 4'd3;
  localparam logic [OFF_W-1:0] REG_LY    = 4'd4;
  localparam logic [OFF_W-1:0] REG_LYC   = 4'd5;
  localparam logic [OFF_W-1:0] REG_DMA   = 4'd6;
  localparam logic [OFF_W-1:0] REG_BGP   = 4'd7;
  localparam logic [OFF_W-1:0] REG_OBP0  = 4'd8;
  localparam logic [OFF_W-1:0] REG_OBP1  = 4'd9;
  localparam logic [OFF_W-1:0] REG_WY    = 4'd10;
  localparam logic [OFF_W-1:0] REG_WX    = 4'd11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HBLANK     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VBLANK_LN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OAM        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_XFER       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VBLANK_1ST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LAST = 3'd5;

  localparam logic [THR_W-1:0]  HBLANK_RST     = 10'd204;
  localparam logic [THR_W-1:0]  VBLANK_LN_RST  = 10'd456;
  localparam logic [THR_W-1:0]  OAM_RST        = 10'd80;
  localparam logic [THR_W-1:0]  XFER_RST       = 10'd172;
  localparam logic [LINE_W-1:0] VBLANK_1ST_RST = 8'd144;
  localparam logic [LINE_W-1:0] FRAME_LAST_RST = 8'd153;

  localparam logic [BYTE_W-1:0] STAT_WRITE_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] STAT_KEEP_MASK  = 8'h07;
  localparam int CTRL_ENABLE_BIT = 7;

  // status interrupt enables, bits 6:3 of the status byte
  localparam int IE_HBLANK = 0;
  localparam int IE_VBLANK = 1;
  localparam int IE_OAM    = 2;
  localparam int IE_COINC  = 3;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_sts_t;

endpackage

/* hw/rtl/lmtc_rem_unit.sv */
// Iterative remainder unit: one compare-subtract step per cycle.
// Depends on lmtc_pkg (widths, step count, status struct).
module lmtc_rem_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lmtc_pkg::ACC_W-1:0] dividend,
  input  logic [lmtc_pkg::THR_W-1:0] divisor,
  output logic [lmtc_pkg::THR_W-1:0] rem,
  output lmtc_pkg::rem_sts_t         sts
);
  import lmtc_pkg::*;

  logic [ACC_W-1:0]     r_r;
  logic [REM_DW-1:0]    d_r;
  logic [REM_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic                 fits;

  // shifted divisor fits under the partial remainder
  assign fits = ({{(REM_DW-ACC_W){1'b0}}, r_r} >= d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= REM_CNT_W'(REM_STEPS);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - REM_CNT_W'(1);
      done_r <= (cnt_r == REM_CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r_r <= dividend;
      d_r <= {divisor, {(ACC_W-1){1'b0}}};
    end else if (cnt_r != '0) begin
      if (fits) begin
        r_r <= r_r - d_r[ACC_W-1:0];
      end
      d_r <= d_r >> 1;
    end
  end

  assign rem      = r_r[THR_W-1:0];
  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;

endmodule

/* hw/rtl/lcd_mode_timing_controller.sv */
// LCD mode/status timing controller: sequencer, register file and output stage.
// Depends on lmtc_pkg and lmtc_rem_unit.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+----------------------------
//   in      | in_func, in_cycle_count, in_reg_offset, | in_valid / in_stall
//           | in_write_data                           |
//   out     | out_read_data .. out_current_line       | out_valid / out_stall
//   cfg     | cfg_index, cfg_wdata                    | cfg_we, no wait
//
// A tick item with the display on goes from acceptance through the add state and
// the shift-subtract remainder steps to the update state; reads, writes and ticks
// with the display off go straight to the update state, which waits on out_stall.
// in_stall is high from acceptance until the result is loaded into the output
// register; the next item is taken while that result still waits on out_stall.
// Reset (synchronous, active low) restores the configuration, sequencer, timing,
// display and out_valid registers; latched item, threshold, output data are not.
module lcd_mode_timing_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [lmtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmtc_pkg::CFG_W-1:0]      cfg_wdata,
  // input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_func,
  input  logic [lmtc_pkg::CNT_W-1:0]      in_cycle_count,
  input  logic [lmtc_pkg::OFF_W-1:0]      in_reg_offset,
  input  logic [lmtc_pkg::BYTE_W-1:0]     in_write_data,
  // result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lmtc_pkg::BYTE_W-1:0]     out_read_data,
  output logic                            out_unmapped_read,
  output logic                            out_lcd_irq,
  output logic                            out_dma_start,
  output logic [lmtc_pkg::BYTE_W-1:0]     out_dma_source,
  output logic [1:0]                      out_current_mode,
  output logic [lmtc_pkg::LINE_W-1:0]     out_current_line
);
  import lmtc_pkg::*;

  // ---------------- configuration registers ----------------
  logic [THR_W-1:0]  hblank_cyc_r, vblank_cyc_r, oam_cyc_r, xfer_cyc_r;
  logic [LINE_W-1:0] vblank_1st_r, frame_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hblank_cyc_r <= HBLANK_RST;
      vblank_cyc_r <= VBLANK_LN_RST;
      oam_cyc_r    <= OAM_RST;
      xfer_cyc_r   <= XFER_RST;
      vblank_1st_r <= VBLANK_1ST_RST;
      frame_last_r <= FRAME_LAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HBLANK:     hblank_cyc_r <= cfg_wdata;
        CFG_VBLANK_LN:  vblank_cyc_r <= cfg_wdata;
        CFG_OAM:        oam_cyc_r    <= cfg_wdata;
        CFG_XFER:       xfer_cyc_r   <= cfg_wdata;
        CFG_VBLANK_1ST: vblank_1st_r <= cfg_wdata[LINE_W-1:0];
        CFG_FRAME_LAST: frame_last_r <= cfg_wdata[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  seq_state_t state_r, state_nxt;
  logic       in_acc, out_free, add_en, fin_en, rem_start;
  rem_sts_t   rem_sts;
  logic [THR_W-1:0] rem_val;

  // architectural state
  mode_t             mode_r, mode_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              disp_en_r, disp_en_nxt;
  logic [BYTE_W-1:0] ctrl_r, ctrl_nxt;
  logic [4:0]        stat_hi_r, stat_hi_nxt;   // status bits 7:3
  logic              coinc_r, coinc_nxt;
  logic [BYTE_W-1:0] scy_r, scy_nxt, scx_r, scx_nxt, lyc_r, lyc_nxt;
  logic [BYTE_W-1:0] bgp_r, bgp_nxt, obp0_r, obp0_nxt, obp1_r, obp1_nxt;
  logic [BYTE_W-1:0] wy_r, wy_nxt, wx_r, wx_nxt;

  // latched item and threshold
  func_t             item_func_r;
  logic [CNT_W-1:0]  item_cnt_r;
  logic [OFF_W-1:0]  item_off_r;
  logic [BYTE_W-1:0] item_data_r;
  logic [THR_W-1:0]  thr_r, thr_nxt, thr_sel, thr_raw;
  logic [ACC_W-1:0]  acc_sum;

  // output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] o_rd_r, o_rd_nxt, o_dsrc_r, o_dsrc_nxt;
  logic              o_unm_r, o_unm_nxt, o_irq_r, o_irq_nxt, o_dma_r, o_dma_nxt;

  // scratch for the update step
  logic [LINE_W-1:0] line_inc;
  logic [BYTE_W-1:0] stat_byte, stat_wr;
  logic              wrapped;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (func_t'(in_func) == FUNC_TICK && disp_en_r) ? ST_ADD : ST_FIN;
        end
      end
      ST_ADD: state_nxt = ST_REM;
      ST_REM: begin
        if (rem_sts.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    add_en    = (state_r == ST_ADD);
    rem_start = (state_r == ST_ADD);
    fin_en    = (state_r == ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_func_r <= func_t'(in_func);
      item_cnt_r  <= in_cycle_count;
      item_off_r  <= in_reg_offset;
      item_data_r <= in_write_data;
    end
  end

  // threshold of the current mode; a zero register acts as one
  always_comb begin
    case (mode_r)
      MODE_HBLANK: thr_raw = hblank_cyc_r;
      MODE_VBLANK: thr_raw = vblank_cyc_r;
      MODE_OAM:    thr_raw = oam_cyc_r;
      default:     thr_raw = xfer_cyc_r;
    endcase
    thr_sel = (thr_raw == '0) ? THR_W'(1) : thr_raw;
  end

  assign acc_sum = acc_r + {{(ACC_W-CNT_W){1'b0}}, item_cnt_r};

  lmtc_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (acc_sum),
    .divisor  (thr_sel),
    .rem      (rem_val),
    .sts      (rem_sts)
  );

  assign stat_byte = {stat_hi_r, 3'b000} | ({5'b0, coinc_r, mode_r} & STAT_KEEP_MASK);
  assign stat_wr   = item_data_r & STAT_WRITE_MASK;
  assign line_inc  = line_r + LINE_W'(1);
  assign wrapped   = (acc_r >= {{(ACC_W-THR_W){1'b0}}, thr_r});

  // ---------------- update step ----------------
  always_comb begin
    mode_nxt    = mode_r;
    acc_nxt     = acc_r;
    line_nxt    = line_r;
    disp_en_nxt = disp_en_r;
    ctrl_nxt    = ctrl_r;
    stat_hi_nxt = stat_hi_r;
    coinc_nxt   = coinc_r;
    scy_nxt     = scy_r;
    scx_nxt     = scx_r;
    lyc_nxt     = lyc_r;
    bgp_nxt     = bgp_r;
    obp0_nxt    = obp0_r;
    obp1_nxt    = obp1_r;
    wy_nxt      = wy_r;
    wx_nxt      = wx_r;
    thr_nxt     = thr_r;
    o_rd_nxt    = '0;
    o_unm_nxt   = 1'b0;
    o_irq_nxt   = 1'b0;
    o_dma_nxt   = 1'b0;
    o_dsrc_nxt  = '0;

    if (add_en) begin
      acc_nxt = acc_sum;
      thr_nxt = thr_sel;
    end

    if (fin_en) begin
      case (item_func_r)
        FUNC_TICK: begin
          // acc_r already holds the sum; display-off ticks never reach ST_ADD
          if (disp_en_r && wrapped) begin
            acc_nxt = {{(ACC_W-THR_W){1'b0}}, rem_val};
            case (mode_r)
              MODE_HBLANK: begin
                line_nxt  = line_inc;
                coinc_nxt = (line_inc == lyc_r);
                o_irq_nxt = coinc_nxt && stat_hi_r[IE_COINC];
                if (line_inc == vblank_1st_r) begin
                  o_irq_nxt = o_irq_nxt || stat_hi_r[IE_VBLANK];
                  mode_nxt  = MODE_VBLANK;
                end else begin
                  o_irq_nxt = o_irq_nxt || stat_hi_r[IE_OAM];
                  mode_nxt  = MODE_OAM;
                end
              end
              MODE_VBLANK: begin
                if (line_r >= frame_last_r) begin
                  line_nxt  = '0;
                  coinc_nxt = (lyc_r == '0);
                  o_irq_nxt = (coinc_nxt && stat_hi_r[IE_COINC]) || stat_hi_r[IE_OAM];
                  mode_nxt  = MODE_OAM;
                end else begin
                  line_nxt  = line_inc;
                  coinc_nxt = (line_inc == lyc_r);
                  o_irq_nxt = coinc_nxt && stat_hi_r[IE_COINC];
                end
              end
              MODE_OAM: mode_nxt = MODE_XFER;
              default: begin
                o_irq_nxt = stat_hi_r[IE_HBLANK];
                mode_nxt  = MODE_HBLANK;
              end
            endcase
          end
        end
        FUNC_READ: begin
          unique case (item_off_r)
            REG_CTRL: o_rd_nxt = ctrl_r;
            REG_STAT: o_rd_nxt = stat_byte;
            REG_SCY:  o_rd_nxt = scy_r;
            REG_SCX:  o_rd_nxt = scx_r;
            REG_LY:   o_rd_nxt = line_r;
            REG_LYC:  o_rd_nxt = lyc_r;
            REG_BGP:  o_rd_nxt = bgp_r;
            REG_OBP0: o_rd_nxt = obp0_r;
            REG_OBP1: o_rd_nxt = obp1_r;
            REG_WY:   o_rd_nxt = wy_r;
            REG_WX:   o_rd_nxt = wx_r;
            default:  o_unm_nxt = 1'b1;  // dma and unused offsets
          endcase
        end
        FUNC_WRITE: begin
          unique case (item_off_r)
            REG_CTRL: begin
              if (disp_en_r && !item_data_r[CTRL_ENABLE_BIT]) begin
                // display off: timing and display registers back to reset
                stat_hi_nxt = '0;
                coinc_nxt   = 1'b0;
                scy_nxt     = '0;
                scx_nxt     = '0;
                line_nxt    = '0;
                lyc_nxt     = '0;
                bgp_nxt     = '0;
                obp0_nxt    = '0;
                obp1_nxt    = '0;
                wy_nxt      = '0;
                wx_nxt      = '0;
                acc_nxt     = '0;
                mode_nxt    = MODE_OAM;
                disp_en_nxt = 1'b0;
              end else if (!disp_en_r && item_data_r[CTRL_ENABLE_BIT]) begin
                disp_en_nxt = 1'b1;
              end
              ctrl_nxt = item_data_r;
            end
            REG_STAT: stat_hi_nxt = stat_wr[BYTE_W-1:3];
            REG_SCY:  scy_nxt     = item_data_r;
            REG_SCX:  scx_nxt     = item_data_r;
            REG_LY:   line_nxt    = '0;
            REG_LYC:  lyc_nxt     = item_data_r;
            REG_DMA: begin
              o_dma_nxt  = 1'b1;
              o_dsrc_nxt = item_data_r;
            end
            REG_BGP:  bgp_nxt     = item_data_r;
            REG_OBP0: obp0_nxt    = item_data_r;
            REG_OBP1: obp1_nxt    = item_data_r;
            REG_WY:   wy_nxt      = item_data_r;
            REG_WX:   wx_nxt      = item_data_r;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_OAM;
      acc_r     <= '0;
      line_r    <= '0;
      disp_en_r <= 1'b1;
      ctrl_r    <= '0;
      stat_hi_r <= '0;
      coinc_r   <= 1'b0;
      scy_r     <= '0;
      scx_r     <= '0;
      lyc_r     <= '0;
      bgp_r     <= '0;
      obp0_r    <= '0;
      obp1_r    <= '0;
      wy_r      <= '0;
      wx_r      <= '0;
    end else begin
      mode_r    <= mode_nxt;
      acc_r     <= acc_nxt;
      line_r    <= line_nxt;
      disp_en_r <= disp_en_nxt;
      ctrl_r    <= ctrl_nxt;
      stat_hi_r <= stat_hi_nxt;
      coinc_r   <= coinc_nxt;
      scy_r     <= scy_nxt;
      scx_r     <= scx_nxt;
      lyc_r     <= lyc_nxt;
      bgp_r     <= bgp_nxt;
      obp0_r    <= obp0_nxt;
      obp1_r    <= obp1_nxt;
      wy_r      <= wy_nxt;
      wx_r      <= wx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    thr_r <= thr_nxt;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_en) begin
      o_rd_r   <= o_rd_nxt;
      o_unm_r  <= o_unm_nxt;
      o_irq_r  <= o_irq_nxt;
      o_dma_r  <= o_dma_nxt;
      o_dsrc_r <= o_dsrc_nxt;
      out_current_mode <= mode_nxt;
      out_current_line <= line_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = o_rd_r;
  assign out_unmapped_read = o_unm_r;
  assign out_lcd_irq       = o_irq_r;
  assign out_dma_start     = o_dma_r;
  assign out_dma_source    = o_dsrc_r;

  // ---------------- assertions ----------------
  // a new result only ever comes from the update step
  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result loaded outside update step");

  // with the display off the timing state is frozen at its reset point
  a_off_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !disp_en_r |-> (mode_r == MODE_OAM && acc_r == '0 && line_r == '0))
    else $error("timing state moved while display off");

  // the reduced accumulator is always below the threshold used
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_en && item_func_r == FUNC_TICK && disp_en_r && wrapped) |-> (rem_val < thr_r))
    else $error("remainder not below threshold");

  // the remainder unit is busy only while the sequencer waits on it
  a_rem_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rem_sts.busy |-> (state_r == ST_REM))
    else $error("remainder unit busy outside wait state");

endmodule
